/* src/fvm_pkg.sv */
// shared constants, codes and types for the four voice tone and noise mixer
// no dependencies; used by every module under src
package fvm_pkg;

   localparam int NUM_CH            = 4;
   localparam int NUM_SQUARE        = 3;
   localparam int NOISE_DEPTH_DFLT  = 32768;

   localparam int FREQ_W            = 17;
   localparam int INC_W             = 16;
   localparam int VOL_W             = 8;
   localparam int PHASE_W           = 32;
   localparam int SUM_W             = 26;
   localparam int AMPL_SHIFT        = 15;  // amplitude 32767 = 2^15 - 1
   localparam int MAG_W             = VOL_W + AMPL_SHIFT;

   // square voice sign bit of the phase
   localparam int SQUARE_BIT        = 13;
   // noise table index taken from phase bits 31..8
   localparam int NOISE_SHIFT       = 8;

   localparam logic [PHASE_W-1:0] LFSR_SEED = 32'h0000_0001;
   localparam logic [PHASE_W-1:0] LFSR_TAP  = 32'h0800_0001;

   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic [NUM_SQUARE-1:0]           square_neg;
      logic [NUM_CH-1:0][VOL_W-1:0]    volume;
   } voice_snap_type;

endpackage

/* src/fvm_noise_rom.sv */
// noise bit memory with its fill sequencer run once after reset
// depends on fvm_pkg
module fvm_noise_rom #(
   parameter int NOISE_DEPTH = fvm_pkg::NOISE_DEPTH_DFLT,
   localparam int IDX_W = $clog2(NOISE_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic             rd_data,
   output logic             fill_done
);

   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NOISE_DEPTH - 1);

   logic                        mem [0:NOISE_DEPTH-1];
   logic [fvm_pkg::PHASE_W-1:0] lfsr_ff, lfsr_in, lfsr_shift;
   logic [IDX_W-1:0]            fill_addr_ff;
   logic                        filling_ff;
   logic                        rd_data_ff;

   always_comb begin
      lfsr_shift = {lfsr_ff[fvm_pkg::PHASE_W-2:0], 1'b0};
      lfsr_in    = lfsr_shift[fvm_pkg::PHASE_W-1] ? (lfsr_shift ^ fvm_pkg::LFSR_TAP)
                                                  : lfsr_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff      <= fvm_pkg::LFSR_SEED;
         fill_addr_ff <= '0;
         filling_ff   <= 1'b1;
      end else if (filling_ff) begin
         lfsr_ff <= lfsr_in;
         if (fill_addr_ff == LAST_ADDR) begin
            filling_ff <= 1'b0;
         end else begin
            fill_addr_ff <= fill_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (filling_ff) begin
         mem[fill_addr_ff] <= lfsr_in[0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign fill_done = !filling_ff;

endmodule

/* src/fvm_voice_bank.sv */
// per channel phase, increment and volume registers plus noise index tracking
// depends on fvm_pkg
module fvm_voice_bank #(
   parameter int NOISE_DEPTH = fvm_pkg::NOISE_DEPTH_DFLT,
   localparam int IDX_W = $clog2(NOISE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          set_en,
   input  logic [1:0]                    set_channel,
   input  logic [fvm_pkg::FREQ_W-1:0]    set_freq,
   input  logic [fvm_pkg::VOL_W-1:0]     set_volume,
   input  logic                          tick_en,
   output fvm_pkg::voice_snap_type       snap,
   output logic [IDX_W-1:0]              noise_idx
);

   localparam int SW       = IDX_W + 2;
   localparam int WRAP_REM = (1 << 24) % NOISE_DEPTH;
   localparam logic [SW-1:0] DEPTH_S = SW'(NOISE_DEPTH);
   localparam logic [SW-1:0] WRAP_S  = SW'(WRAP_REM);
   localparam int NC = fvm_pkg::NUM_CH - 1;

   logic [fvm_pkg::PHASE_W-1:0] phase_ff [fvm_pkg::NUM_CH];
   logic [fvm_pkg::PHASE_W-1:0] phase_in [fvm_pkg::NUM_CH];
   logic [fvm_pkg::INC_W-1:0]   inc_ff   [fvm_pkg::NUM_CH];
   logic [fvm_pkg::VOL_W-1:0]   vol_ff   [fvm_pkg::NUM_CH];
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [8:0]                  hi_delta;
   logic                        wrap;
   logic [SW-1:0]               t_sum, t_red, t_wrap;

   always_comb begin
      for (int c = 0; c < fvm_pkg::NUM_CH; c++) begin
         phase_in[c] = phase_ff[c] + fvm_pkg::PHASE_W'(inc_ff[c]);
      end
   end

   // index bits 31..8 move by at most 256 a tick; a phase wrap drops 2^24 from
   // the natural index, which is folded back as its remainder
   always_comb begin
      hi_delta = phase_in[NC][16:8] - phase_ff[NC][16:8];
      wrap     = phase_in[NC] < phase_ff[NC];
      t_sum    = SW'(idx_ff) + SW'(hi_delta);
      t_red    = (t_sum >= DEPTH_S) ? (t_sum - DEPTH_S) : t_sum;
      if (!wrap) begin
         t_wrap = t_red;
      end else if (t_red >= WRAP_S) begin
         t_wrap = t_red - WRAP_S;
      end else begin
         t_wrap = t_red + DEPTH_S - WRAP_S;
      end
      idx_in = t_wrap[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < fvm_pkg::NUM_CH; c++) begin
            phase_ff[c] <= '0;
            inc_ff[c]   <= '0;
            vol_ff[c]   <= '0;
         end
         idx_ff <= '0;
      end else if (set_en) begin
         inc_ff[set_channel] <= set_freq[fvm_pkg::FREQ_W-1:1];
         vol_ff[set_channel] <= set_volume;
      end else if (tick_en) begin
         for (int c = 0; c < fvm_pkg::NUM_CH; c++) begin
            phase_ff[c] <= phase_in[c];
         end
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      for (int c = 0; c < fvm_pkg::NUM_SQUARE; c++) begin
         snap.square_neg[c] = phase_ff[c][fvm_pkg::SQUARE_BIT];
      end
      for (int c = 0; c < fvm_pkg::NUM_CH; c++) begin
         snap.volume[c] = vol_ff[c];
      end
   end

   assign noise_idx = idx_ff;

endmodule

/* src/fvm_mixer.sv */
// weights the four voice signs by their volumes and sums them
// depends on fvm_pkg
module fvm_mixer (
   input  fvm_pkg::voice_snap_type            snap,
   input  logic                               noise_bit,
   output logic signed [fvm_pkg::SUM_W-1:0]   sum
);

   logic [fvm_pkg::MAG_W-1:0]          mag  [fvm_pkg::NUM_CH];
   logic                               neg  [fvm_pkg::NUM_CH];
   logic signed [fvm_pkg::SUM_W-1:0]   term [fvm_pkg::NUM_CH];

   always_comb begin
      for (int c = 0; c < fvm_pkg::NUM_CH; c++) begin
         // volume times 32767 as a shift and subtract
         mag[c] = {snap.volume[c], fvm_pkg::AMPL_SHIFT'(0)}
                - fvm_pkg::MAG_W'(snap.volume[c]);
      end
      for (int c = 0; c < fvm_pkg::NUM_SQUARE; c++) begin
         neg[c] = snap.square_neg[c];
      end
      neg[fvm_pkg::NUM_CH-1] = !noise_bit;
      sum = '0;
      for (int c = 0; c < fvm_pkg::NUM_CH; c++) begin
         term[c] = neg[c] ? -$signed(fvm_pkg::SUM_W'(mag[c]))
                          :  $signed(fvm_pkg::SUM_W'(mag[c]));
         sum     = sum + term[c];
      end
   end

endmodule

/* src/four_voice_tone_noise_mixer.sv */
// top level of the four voice tone and noise mixer
// depends on fvm_pkg, fvm_noise_rom, fvm_voice_bank, fvm_mixer
//
//   channel | ports                                   | direction | moves
//   req     | req_valid/ready, command, channel,      | in        | set or tick
//           | frequency_word, volume                  |           | transaction
//   rsp     | rsp_valid/ready, sample_sum             | out       | one sample per tick
//
// one transaction per cycle while rsp is not stalled; a tick's sample passes the
// noise memory read register, then the result register
// a set transaction updates state at acceptance and gives no result
// after reset the noise memory is filled one entry a cycle, with req_ready
// low for that whole sweep
// a stalled rsp holds the sample stage; req_ready drops only when both are full
module four_voice_tone_noise_mixer #(
   parameter int NOISE_DEPTH = fvm_pkg::NOISE_DEPTH_DFLT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [1:0]                        req_channel,
   input  logic [fvm_pkg::FREQ_W-1:0]        req_frequency_word,
   input  logic [fvm_pkg::VOL_W-1:0]         req_volume,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [fvm_pkg::SUM_W-1:0]  rsp_sample_sum
);

   localparam int IDX_W = $clog2(NOISE_DEPTH);

   logic                              fill_done;
   logic                              req_acc, tick_acc, set_acc;
   logic                              out_free, s1_adv;
   logic [IDX_W-1:0]                  noise_idx;
   logic                              noise_bit;
   fvm_pkg::voice_snap_type           snap_now;
   fvm_pkg::voice_snap_type           snap_ff;
   logic                              s1_valid_ff, s1_valid_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [fvm_pkg::SUM_W-1:0]  rsp_sum_ff;
   logic signed [fvm_pkg::SUM_W-1:0]  mix_sum;

   // handshake: the sample stage moves on when the result register is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = fill_done && (!s1_valid_ff || out_free);
   assign req_acc   = req_valid && req_ready;
   assign tick_acc  = req_acc && (req_command == fvm_pkg::CMD_TICK);
   assign set_acc   = req_acc && (req_command == fvm_pkg::CMD_SET);

   fvm_voice_bank #(.NOISE_DEPTH(NOISE_DEPTH)) u_voice_bank (
      .clock       (clock),
      .reset       (reset),
      .set_en      (set_acc),
      .set_channel (req_channel),
      .set_freq    (req_frequency_word),
      .set_volume  (req_volume),
      .tick_en     (tick_acc),
      .snap        (snap_now),
      .noise_idx   (noise_idx)
   );

   // noise bit is read at the tick's pre-advance index, alongside the snapshot
   fvm_noise_rom #(.NOISE_DEPTH(NOISE_DEPTH)) u_noise_rom (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (tick_acc),
      .rd_addr   (noise_idx),
      .rd_data   (noise_bit),
      .fill_done (fill_done)
   );

   fvm_mixer u_mixer (
      .snap      (snap_ff),
      .noise_bit (noise_bit),
      .sum       (mix_sum)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (tick_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (tick_acc) begin
         snap_ff <= snap_now;
      end
      if (s1_adv) begin
         rsp_sum_ff <= mix_sum;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_sum = rsp_sum_ff;

   // no transaction taken while the noise memory is still being filled
   assert property (@(posedge clock) disable iff (reset) !fill_done |-> !req_ready)
      else $error("request accepted during noise fill");

   // an accepted tick always occupies the sample stage next cycle
   assert property (@(posedge clock) disable iff (reset) tick_acc |=> s1_valid_ff)
      else $error("tick lost before sample stage");

   // a waiting sample stage is never dropped while the result is stalled
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("sample stage dropped under stall");

   // a stage advance always produces a valid result
   assert property (@(posedge clock) disable iff (reset) s1_adv |=> rsp_valid_ff)
      else $error("sample advance without result");

endmodule

/* dv/four_voice_tone_noise_mixer_tb.sv */
// self-checking testbench for four_voice_tone_noise_mixer: directed voice setups, random
// set/tick traffic under sender and receiver idling, and a long output stall
// depends on fvm_pkg and the mixer rtl under src
module four_voice_tone_noise_mixer_tb;
   import fvm_pkg::*;

   localparam int NOISE_DEPTH  = NOISE_DEPTH_DFLT;
   localparam int NOISE_VOICE  = NUM_SQUARE;       // the last channel is the noise voice
   localparam int VOICE_PEAK   = 32767;
   localparam int DRAIN_CYCLES = 16;               // well past the sample latency
   localparam int STALL_CYCLES = 300;
   localparam int RUN_LIMIT    = 2000000;          // time units

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel, all driven from time zero
   logic                    req_valid          = 1'b0;
   logic                    req_ready;
   logic                    req_command        = CMD_TICK;
   logic [1:0]              req_channel        = '0;
   logic [FREQ_W-1:0]       req_frequency_word = '0;
   logic [VOL_W-1:0]        req_volume         = '0;

   // response channel
   logic                    rsp_valid;
   logic                    rsp_ready          = 1'b0;
   logic signed [SUM_W-1:0] rsp_sample_sum;

   // idling control; rsp_stall forces a long hold-off of rsp_ready
   int   send_idle_pct = 0;
   int   rsp_idle_pct  = 0;
   logic rsp_stall     = 1'b0;
   int   mismatch_count = 0;

   // predictor state
   logic [PHASE_W-1:0]      voice_phase [NUM_CH];
   logic [INC_W-1:0]        voice_step  [NUM_CH];
   logic [VOL_W-1:0]        voice_level [NUM_CH];
   bit                      noise_table [NOISE_DEPTH];

   // samples predicted for accepted ticks, oldest first
   logic signed [SUM_W-1:0] expected_samples [$];

   four_voice_tone_noise_mixer #(
      .NOISE_DEPTH (NOISE_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_channel        (req_channel),
      .req_frequency_word (req_frequency_word),
      .req_volume         (req_volume),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sample_sum     (rsp_sample_sum)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(RUN_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // sum of the four weighted voices at the current phases
   function automatic logic signed [SUM_W-1:0] mix_sample();
      int sum;
      int level;
      int idx;
      sum = 0;
      for (int i = 0; i < NUM_CH; i++) begin
         if (i == NOISE_VOICE) begin
            idx = int'((voice_phase[i] >> NOISE_SHIFT) % NOISE_DEPTH);
            level = noise_table[idx] ? VOICE_PEAK : -VOICE_PEAK;
         end else begin
            // square voice is high while phase bit 13 is clear
            level = voice_phase[i][SQUARE_BIT] ? -VOICE_PEAK : VOICE_PEAK;
         end
         sum += int'(voice_level[i]) * level;
      end
      mix_sample = sum[SUM_W-1:0];
   endfunction

   // predictor: follows every accepted request transaction
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            voice_phase[i] = '0;
            voice_step[i]  = '0;
            voice_level[i] = '0;
         end
      end else if (req_valid && req_ready) begin
         if (req_command == CMD_SET) begin
            // only increment and volume change, the phase keeps running
            voice_step[req_channel]  = req_frequency_word[FREQ_W-1:1];
            voice_level[req_channel] = req_volume;
         end else begin
            // sample from the phases as they stand, then advance with wrap
            expected_samples.push_back(mix_sample());
            for (int i = 0; i < NUM_CH; i++)
               voice_phase[i] = voice_phase[i] + PHASE_W'(voice_step[i]);
         end
      end
   end

   // checker: each response transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample, expected none, actual %0d",
                     $time, rsp_sample_sum);
            mismatch_count++;
         end else if (expected_samples[0] !== rsp_sample_sum) begin
            $display("%0t: sample mismatch, expected %0d, actual %0d",
                     $time, expected_samples[0], rsp_sample_sum);
            mismatch_count++;
            void'(expected_samples.pop_front());
         end else begin
            void'(expected_samples.pop_front());
         end
      end
   end

   // receiver: random ready, or held low during a forced stall
   always @(posedge clock) begin
      if (rsp_stall)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // offer one request transaction and wait until it is taken
   task automatic send_item(input logic cmd, input logic [1:0] ch,
                            input logic [FREQ_W-1:0] freq, input logic [VOL_W-1:0] vol);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_channel        <= ch;
      req_frequency_word <= freq;
      req_volume         <= vol;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // frequency words lean toward the ends of the range
   function automatic logic [FREQ_W-1:0] pick_frequency();
      logic [FREQ_W-1:0] f;
      case ($urandom_range(7))
         0: f = '0;
         1: f = '1;
         2: f = FREQ_W'($urandom_range(255));
         default: f = FREQ_W'($urandom());
      endcase
      return f;
   endfunction

   function automatic logic [VOL_W-1:0] pick_volume();
      logic [VOL_W-1:0] v;
      case ($urandom_range(5))
         0: v = '0;
         1: v = '1;
         default: v = VOL_W'($urandom());
      endcase
      return v;
   endfunction

   // extremes of every field, every channel, silent voices, ignored tick fields
   task automatic test_directed_voices();
      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      send_item(CMD_TICK, 2'd0, '0, '0);                // everything silent after reset
      send_item(CMD_SET,  2'd0, '1, '1);                // max increment, full volume
      send_item(CMD_SET,  2'd1, FREQ_W'(1), '1);        // lsb drops, increment zero
      send_item(CMD_SET,  2'd2, FREQ_W'(17'h10000), VOL_W'(1));
      send_item(CMD_SET,  2'd3, FREQ_W'(17'h1fffe), '1);
      send_item(CMD_TICK, 2'd0, '0, '0);
      send_item(CMD_TICK, 2'd0, '0, '0);
      send_item(CMD_TICK, 2'd3, '1, '1);                // junk on unused tick fields
      send_item(CMD_SET,  2'd0, '1, '0);                // silence a running voice
      send_item(CMD_TICK, 2'd2, FREQ_W'(17'h0aaaa), VOL_W'(8'h55));
      send_item(CMD_SET,  2'd2, FREQ_W'(17'h04000), VOL_W'(128)); // bit 13 flips each tick
      send_item(CMD_TICK, 2'd1, '0, '0);
      send_item(CMD_TICK, 2'd0, '0, '0);
      send_item(CMD_TICK, 2'd0, '0, '0);
      send_item(CMD_SET,  2'd0, FREQ_W'(17'h00002), '1);
      send_item(CMD_SET,  2'd1, FREQ_W'(17'h1fffe), '1);
      send_item(CMD_SET,  2'd2, '1, '1);
      send_item(CMD_SET,  2'd3, '0, '1);                // noise voice frozen
      send_item(CMD_TICK, 2'd0, '0, '0);
      send_item(CMD_TICK, 2'd1, FREQ_W'(17'h15555), VOL_W'(8'haa));
      send_item(CMD_TICK, 2'd0, '0, '0);
      send_item(CMD_SET,  2'd3, '1, '1);                // noise voice at max step
      send_item(CMD_TICK, 2'd0, '0, '0);
      send_item(CMD_TICK, 2'd0, '0, '0);
   endtask

   // random set and tick traffic at the given idle rates
   task automatic test_random_mix(input int count, input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct <= rsp_pct;
      repeat (count) begin
         if ($urandom_range(99) < 35)
            send_item(CMD_SET, 2'($urandom()), pick_frequency(), pick_volume());
         else
            send_item(CMD_TICK, 2'($urandom()), FREQ_W'($urandom()), VOL_W'($urandom()));
      end
   endtask

   // receiver holds off for a long stretch while ticks keep coming, so the
   // sample stages fill and req_ready has to drop
   task automatic test_output_stall();
      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      fork
         begin
            rsp_stall <= 1'b1;
            repeat (STALL_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      join_none
      repeat (40)
         send_item(CMD_TICK, 2'($urandom()), FREQ_W'($urandom()), VOL_W'($urandom()));
   endtask

   initial begin
      logic [PHASE_W-1:0] lfsr;

      // noise table as the block fills it after reset
      lfsr = LFSR_SEED;
      for (int i = 0; i < NOISE_DEPTH; i++) begin
         lfsr = lfsr << 1;
         if (lfsr[PHASE_W-1])
            lfsr ^= LFSR_TAP;
         noise_table[i] = lfsr[0];
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // first request waits out the noise table sweep on req_ready
      test_directed_voices();
      test_random_mix(400, 28, 61);
      test_random_mix(400, 61, 28);
      test_output_stall();
      test_random_mix(400, 0, 0);

      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
